// File: rtl/lsfg_pkg.sv
// Shared constants and mode codes for the LED strip frame generator.
package lsfg_pkg;

  // Default number of LEDs on the strip.
  localparam int unsigned DefLedCount = 8;

  // Input mode codes.
  localparam logic [1:0] ModeWrite = 2'd0;
  localparam logic [1:0] ModeShow  = 2'd1;
  localparam logic [1:0] ModeLevel = 2'd2;

  // Fixed bytes of the frame and LED word.
  localparam logic [2:0] HeaderBits = 3'b111;
  localparam logic [7:0] StartByte  = 8'h00;
  localparam logic [7:0] EndByte    = 8'hFF;
  localparam logic [7:0] FullColor  = 8'hFF;
  localparam logic [4:0] FullBright = 5'h1F;
  localparam int unsigned FullScale = 255;

  // Number of start bytes ahead of the LED words.
  localparam int unsigned StartLen = 4;

  // Build one LED word: header with brightness, then blue, green and red.
  function automatic logic [31:0] pack_word(logic [4:0] bright, logic [7:0] r,
                                            logic [7:0] g, logic [7:0] b);
    return {HeaderBits, bright, b, g, r};
  endfunction

endpackage

// File: rtl/led_strip_frame_generator.sv
// Top level: LED word store, bar level sweep and frame byte sequencer.
// A show transaction moves from acceptance into the start state, which then registers the first
// byte on the output; a level transaction first sweeps the store, one LED per cycle through a
// shared add-and-compare unit, then emits the frame. The frame is 4 + 4*LED_COUNT +
// (LED_COUNT+1)/2 bytes (40 at 8 LEDs), one byte per cycle when the sink is ready; the input
// stays not ready through the sweep and until the last byte of the frame is registered, so the
// block takes no new transaction while a sweep or a frame is in progress.
// Reset: every LED word returns to header 0xE0 with zero brightness and colors.
module led_strip_frame_generator
  import lsfg_pkg::*;
#(
  parameter int unsigned LED_COUNT = DefLedCount
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // led_addr[7:0], brightness[12:8], red[20:13], green[28:21], blue[36:29],
  // level_sample[44:37], zero fill[47:45]
  input  logic [47:0] s_axis_tdata,
  // mode[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // serial_byte[7:0]
  output logic [7:0]  m_axis_tdata,
  // frame_end
  output logic        m_axis_tlast
);

  localparam int unsigned IdxW    = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int unsigned ProdW   = 8 + $clog2(LED_COUNT + 1);
  localparam int unsigned TailLen = (LED_COUNT + 1) / 2;
  localparam int unsigned CntW    = 3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LEVEL,
    S_START,
    S_LEDS,
    S_TAIL
  } state_e;

  // Unpacked input fields.
  logic [7:0] led_addr;
  logic [4:0] brightness;
  logic [7:0] red, green, blue, level_sample;
  logic [1:0] mode;

  assign led_addr     = s_axis_tdata[7:0];
  assign brightness   = s_axis_tdata[12:8];
  assign red          = s_axis_tdata[20:13];
  assign green        = s_axis_tdata[28:21];
  assign blue         = s_axis_tdata[36:29];
  assign level_sample = s_axis_tdata[44:37];
  assign mode         = s_axis_tuser;

  state_e             state_q;
  logic [IdxW-1:0]    led_q;
  logic [CntW-1:0]    cnt_q;
  logic [ProdW-1:0]   prod_q;
  logic [ProdW-1:0]   acc_q;
  logic [31:0]        led_words_q [LED_COUNT];
  logic               out_valid_q;
  logic               out_last_q;
  logic [7:0]         out_byte_q;

  logic               in_fire;
  logic               out_adv;
  logic               write_hit;
  logic               lit;
  logic [31:0]        cur_word;
  logic [7:0]         led_byte;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_adv       = !out_valid_q || m_axis_tready;
  assign write_hit     = (mode == ModeWrite) && (led_addr < 8'(LED_COUNT));

  // Shared compare: LED i is lit when sample*N >= 255*(i+1).
  assign lit = (prod_q >= acc_q);

  // Byte of the current LED word, most significant byte first.
  assign cur_word = led_words_q[led_q];
  always_comb begin
    case (cnt_q[1:0])
      2'd0:    led_byte = cur_word[31:24];
      2'd1:    led_byte = cur_word[23:16];
      2'd2:    led_byte = cur_word[15:8];
      default: led_byte = cur_word[7:0];
    endcase
  end

  // LED word store, written by single writes and by the level sweep.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LED_COUNT; i++) begin
        led_words_q[i] <= pack_word(5'd0, 8'd0, 8'd0, 8'd0);
      end
    end else if (in_fire && write_hit) begin
      led_words_q[led_addr[IdxW-1:0]] <= pack_word(brightness, red, green, blue);
    end else if (state_q == S_LEVEL) begin
      led_words_q[led_q] <= lit ? pack_word(FullBright, FullColor, 8'd0, 8'd0)
                                : pack_word(5'd0, 8'd0, 8'd0, 8'd0);
    end
  end

  // Sequencer and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      led_q       <= '0;
      cnt_q       <= '0;
      prod_q      <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_byte_q  <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (out_adv) begin
            out_valid_q <= 1'b0;
          end
          if (in_fire) begin
            led_q  <= '0;
            cnt_q  <= '0;
            prod_q <= ProdW'(level_sample) * ProdW'(LED_COUNT);
            acc_q  <= ProdW'(FullScale);
            if (mode == ModeShow) begin
              state_q <= S_START;
            end else if (mode == ModeLevel) begin
              state_q <= S_LEVEL;
            end
          end
        end
        S_LEVEL: begin
          if (out_adv) begin
            out_valid_q <= 1'b0;
          end
          acc_q <= acc_q + ProdW'(FullScale);
          if (led_q == IdxW'(LED_COUNT - 1)) begin
            led_q   <= '0;
            state_q <= S_START;
          end else begin
            led_q <= led_q + 1'b1;
          end
        end
        S_START: begin
          if (out_adv) begin
            out_valid_q <= 1'b1;
            out_last_q  <= 1'b0;
            out_byte_q  <= StartByte;
            if (cnt_q == CntW'(StartLen - 1)) begin
              cnt_q   <= '0;
              state_q <= S_LEDS;
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
          end
        end
        S_LEDS: begin
          if (out_adv) begin
            out_valid_q <= 1'b1;
            out_last_q  <= 1'b0;
            out_byte_q  <= led_byte;
            if (cnt_q[1:0] == 2'd3) begin
              cnt_q <= '0;
              if (led_q == IdxW'(LED_COUNT - 1)) begin
                led_q   <= '0;
                state_q <= S_TAIL;
              end else begin
                led_q <= led_q + 1'b1;
              end
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
          end
        end
        S_TAIL: begin
          if (out_adv) begin
            out_valid_q <= 1'b1;
            out_byte_q  <= EndByte;
            if (cnt_q == CntW'(TailLen - 1)) begin
              out_last_q <= 1'b1;
              cnt_q      <= '0;
              state_q    <= S_IDLE;
            end else begin
              out_last_q <= 1'b0;
              cnt_q      <= cnt_q + 1'b1;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_last_q;

  // The frame always closes on an end byte.
  a_last_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata == EndByte))
    else $error("frame end flagged on a byte other than the end byte");

  // The sweep accumulator tracks 255 times the next LED number.
  a_acc_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LEVEL) |->
      (acc_q == ProdW'(FullScale) * (ProdW'(led_q) + ProdW'(1))))
    else $error("level sweep accumulator out of step with LED counter");

  // The LED counter never points past the strip.
  a_led_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LEVEL || state_q == S_LEDS) |-> (led_q <= IdxW'(LED_COUNT - 1)))
    else $error("LED counter beyond the strip length");

endmodule
